// ----- design/dlcc_pkg.sv -----
// Package for the decision-list confusion counter.
// Holds the shared types, register indexes and sizing constants.
// Used by every module of the block; depends on nothing.
`default_nettype none

package dlcc_pkg;

    localparam int MAX_CUES_DEF   = 16;
    localparam int COUNT_BITS_DEF = 16;

    localparam int FIRE_W  = 16;
    localparam int CNUM_W  = 5;
    localparam int CIDX_W  = 4;
    localparam int FIELD_W = 16;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_CUE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRED_MASK = 2'd1;

    typedef enum logic [1:0] {
        ROW_CASE  = 2'd0,
        ROW_CUE   = 2'd1,
        ROW_UNCL  = 2'd2,
        ROW_TOTAL = 2'd3
    } t_row_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPD,
        ST_SRD,
        ST_SOUT,
        ST_UNC,
        ST_TOT
    } t_back_state;

    // Effective cue count and prediction bits.
    typedef struct packed {
        logic [CNUM_W-1:0] cue_n;
        logic [FIRE_W-1:0] pred_mask;
    } t_cfg;

    // One classified case, as it travels from the front to the back.
    typedef struct packed {
        logic              claimed;
        logic [CIDX_W-1:0] cue;
        logic              pred;
        logic              truth;
        logic              last;
    } t_case;

    typedef struct packed {
        t_row_kind          row_kind;
        logic [CIDX_W-1:0]  cue_index;
        logic               predicted_class;
        logic [CNUM_W-1:0]  claimed_by;
        logic [FIELD_W-1:0] hit_count;
        logic [FIELD_W-1:0] false_alarm_count;
        logic [FIELD_W-1:0] miss_count;
        logic [FIELD_W-1:0] reject_count;
        logic [FIELD_W-1:0] claimed_count;
        logic [FIELD_W-1:0] open_before;
        logic               last;
    } t_row;

endpackage

`default_nettype wire

// ----- design/dlcc_front.sv -----
// Front end: accepts cases and classifies them against the decision list.
// Finds the claiming cue and the prediction and pushes the result to the queue.
// Depends on dlcc_pkg.
`default_nettype none

module dlcc_front
    import dlcc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cfg              i_cfg,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [FIRE_W-1:0] i_cue_fires,
    input  wire logic              i_true_class,
    input  wire logic              i_last_case,
    input  wire logic              i_full,
    output logic                   o_push,
    output t_case                  o_item
);

    logic              w_found;
    logic [CIDX_W-1:0] w_cue;
    logic [CNUM_W-1:0] w_last_cue;
    logic              w_dflt_pred;
    logic              r_busy_unused;

    // Lowest enabled cue that fires wins.
    always_comb begin
        w_found = 1'b0;
        w_cue   = '0;
        for (int i = FIRE_W - 1; i >= 0; i--) begin
            if (i_cue_fires[i] && (CNUM_W'(i) < i_cfg.cue_n)) begin
                w_found = 1'b1;
                w_cue   = CIDX_W'(i);
            end
        end
    end

    // An unclaimed case takes the opposite of the last cue's prediction.
    // Cues beyond the mask predict 0, so their opposite is 1.
    assign w_last_cue = i_cfg.cue_n - CNUM_W'(1);

    always_comb begin
        if (i_cfg.cue_n == '0) begin
            w_dflt_pred = 1'b1;
        end else if (w_last_cue[CNUM_W-1]) begin
            w_dflt_pred = 1'b1;
        end else begin
            w_dflt_pred = ~i_cfg.pred_mask[w_last_cue[CIDX_W-1:0]];
        end
    end

    always_comb begin
        o_item.claimed = w_found;
        o_item.cue     = w_cue;
        o_item.pred    = w_found ? i_cfg.pred_mask[w_cue] : w_dflt_pred;
        o_item.truth   = i_true_class;
        o_item.last    = i_last_case;
    end

    // Ready is held low during reset so nothing enters a half-reset queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy_unused <= 1'b1;
        end else begin
            r_busy_unused <= 1'b0;
        end
    end

    assign o_ready = !i_full && !r_busy_unused;
    assign o_push  = i_valid && o_ready;

endmodule

`default_nettype wire

// ----- design/dlcc_fifo.sv -----
// Short queue of classified cases between the front and the back.
// Lets either side stall without holding up the other.
// Depends on dlcc_pkg.
`default_nettype none

module dlcc_fifo
    import dlcc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_case i_item,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_empty,
    output t_case      o_head
);

    t_case             r_buf [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QPTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_buf[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- design/dlcc_back.sv -----
// Back end: counter memory, read-modify-write of the confusion counts,
// batch-end report sweep and the output register.
// Depends on dlcc_pkg.
`default_nettype none

module dlcc_back
    import dlcc_pkg::*;
#(
    parameter int MAX_CUES   = MAX_CUES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_empty,
    input  wire t_case i_head,
    output logic       o_pop,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_row       o_row
);

    localparam int CUE_W = (MAX_CUES > 1) ? $clog2(MAX_CUES) : 1;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    typedef logic [3:0][COUNT_BITS-1:0] t_cnt4;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] a);
        return (a == CNT_MAX) ? a : a + 1'b1;
    endfunction

    function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
                                                      input logic [COUNT_BITS-1:0] b);
        logic [COUNT_BITS:0] s;
        s = (COUNT_BITS + 1)'(a) + (COUNT_BITS + 1)'(b);
        return s[COUNT_BITS] ? CNT_MAX : s[COUNT_BITS-1:0];
    endfunction

    function automatic logic [COUNT_BITS-1:0] sat_sum4(input t_cnt4 c);
        logic [COUNT_BITS+1:0] s;
        s = (COUNT_BITS + 2)'(c[0]) + (COUNT_BITS + 2)'(c[1])
          + (COUNT_BITS + 2)'(c[2]) + (COUNT_BITS + 2)'(c[3]);
        return (s > (COUNT_BITS + 2)'(CNT_MAX)) ? CNT_MAX : s[COUNT_BITS-1:0];
    endfunction

    function automatic t_row mk_row(input t_row_kind kind, input logic [CIDX_W-1:0] idx,
                                    input logic pc, input logic [CNUM_W-1:0] cb,
                                    input t_cnt4 c, input logic [COUNT_BITS-1:0] open,
                                    input logic lst);
        t_row r;
        r.row_kind          = kind;
        r.cue_index         = idx;
        r.predicted_class   = pc;
        r.claimed_by        = cb;
        r.hit_count         = FIELD_W'(c[0]);
        r.false_alarm_count = FIELD_W'(c[1]);
        r.miss_count        = FIELD_W'(c[2]);
        r.reject_count      = FIELD_W'(c[3]);
        r.claimed_count     = FIELD_W'(sat_sum4(c));
        r.open_before       = FIELD_W'(open);
        r.last              = lst;
        return r;
    endfunction

    t_back_state           r_state, n_state;
    t_case                 r_item, n_item;
    logic [CUE_W-1:0]      r_idx, n_idx;
    t_cnt4                 r_unc, n_unc;
    t_cnt4                 r_tot, n_tot;
    logic [COUNT_BITS-1:0] r_total, n_total;
    logic [COUNT_BITS-1:0] r_open, n_open;
    t_row                  r_out, n_out;
    logic                  r_out_vld, n_out_vld;

    t_cnt4                 r_mem [MAX_CUES];
    t_cnt4                 r_rd_data;
    logic                  r_rd_vld;
    logic [MAX_CUES-1:0]   r_cvalid;

    logic                  w_free;
    logic                  w_rd_en;
    logic [CUE_W-1:0]      w_rd_addr;
    logic                  w_wr_en;
    logic [CUE_W-1:0]      w_wr_addr;
    logic                  w_clear;
    t_cnt4                 w_cnt;
    t_cnt4                 w_base;
    t_cnt4                 w_upd;
    logic [1:0]            w_slot;
    logic [COUNT_BITS-1:0] w_claimed;
    logic [CNUM_W-1:0]     w_claimer;

    assign w_free    = !r_out_vld || i_ready;
    assign w_cnt     = r_rd_vld ? r_rd_data : '0;
    assign w_base    = r_item.claimed ? w_cnt : r_unc;
    // Slot order: hit, false alarm, miss, correct rejection.
    assign w_slot    = {~r_item.pred, ~r_item.truth};
    assign w_claimed = sat_sum4(w_cnt);
    assign w_wr_addr = CUE_W'(r_item.cue);
    assign w_claimer = r_item.claimed ? (CNUM_W'(r_item.cue) + CNUM_W'(1)) : '0;

    always_comb begin
        w_upd         = w_base;
        w_upd[w_slot] = sat_inc(w_base[w_slot]);
    end

    always_comb begin
        n_state   = r_state;
        n_item    = r_item;
        n_idx     = r_idx;
        n_unc     = r_unc;
        n_tot     = r_tot;
        n_total   = r_total;
        n_open    = r_open;
        n_out     = r_out;
        n_out_vld = r_out_vld && !i_ready;
        o_pop     = 1'b0;
        w_rd_en   = 1'b0;
        w_rd_addr = r_idx;
        w_wr_en   = 1'b0;
        w_clear   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop     = 1'b1;
                    n_item    = i_head;
                    w_rd_en   = 1'b1;
                    w_rd_addr = CUE_W'(i_head.cue);
                    n_state   = ST_UPD;
                end
            end
            ST_UPD: begin
                // A batch end sends no case row, so it never waits on the output.
                if (r_item.last || w_free) begin
                    w_wr_en = r_item.claimed;
                    if (!r_item.claimed) begin
                        n_unc = w_upd;
                    end
                    n_total = sat_inc(r_total);
                    if (!r_item.last) begin
                        n_out     = mk_row(ROW_CASE, '0, r_item.pred, w_claimer,
                                           '0, '0, 1'b1);
                        n_out_vld = 1'b1;
                        n_state   = ST_IDLE;
                    end else begin
                        n_open  = sat_inc(r_total);
                        n_tot   = r_item.claimed ? r_unc : w_upd;
                        n_idx   = '0;
                        n_state = (i_cfg.cue_n == '0) ? ST_UNC : ST_SRD;
                    end
                end
            end
            ST_SRD: begin
                w_rd_en = 1'b1;
                n_state = ST_SOUT;
            end
            ST_SOUT: begin
                if (w_free) begin
                    n_out     = mk_row(ROW_CUE, CIDX_W'(r_idx), 1'b0, '0,
                                       w_cnt, r_open, 1'b0);
                    n_out_vld = 1'b1;
                    n_open    = (r_open > w_claimed) ? r_open - w_claimed : '0;
                    for (int j = 0; j < 4; j++) begin
                        n_tot[j] = sat_add(r_tot[j], w_cnt[j]);
                    end
                    if (32'(r_idx) + 1 == 32'(i_cfg.cue_n)) begin
                        n_state = ST_UNC;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = ST_SRD;
                    end
                end
            end
            ST_UNC: begin
                if (w_free) begin
                    n_out     = mk_row(ROW_UNCL, '0, 1'b0, '0, r_unc, r_open, 1'b0);
                    n_out_vld = 1'b1;
                    n_state   = ST_TOT;
                end
            end
            ST_TOT: begin
                if (w_free) begin
                    n_out     = mk_row(ROW_TOTAL, '0, r_item.pred, w_claimer,
                                       r_tot, r_open, 1'b1);
                    n_out_vld = 1'b1;
                    n_unc     = '0;
                    n_total   = '0;
                    w_clear   = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_unc     <= '0;
            r_total   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_unc     <= n_unc;
            r_total   <= n_total;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_idx  <= n_idx;
        r_tot  <= n_tot;
        r_open <= n_open;
        r_out  <= n_out;
    end

    // Per-cue counter memory; an entry without its valid bit reads as zero.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_upd;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
            r_rd_vld  <= r_cvalid[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvalid <= '0;
        end else if (w_clear) begin
            r_cvalid <= '0;
        end else if (w_wr_en) begin
            r_cvalid[w_wr_addr] <= 1'b1;
        end
    end

    assign o_valid = r_out_vld;
    assign o_row   = r_out;

endmodule

`default_nettype wire

// ----- design/decision_list_confusion_counter_top.sv -----
// Decision-list confusion counter: evaluates a fast-and-frugal decision list
// over a stream of cases and reports confusion counts per cue at batch end.
//
// Channels: cases enter on i_in_valid / o_in_ready, result rows leave on
// o_out_valid / i_out_ready, and the two registers (cue count, prediction
// mask) are written on i_cfg_valid / o_cfg_ready, which is always ready.
// Configuration must be written only while the block is idle; the block does
// not enforce this. A case row passes the queue, the back end's idle and update
// states and the output register. The back end takes a new case only once the
// read-modify-write of the per-cue counter memory (registered read, then write
// back) for the last one is done. A case marked last gives no case row but one
// row per cue, then an unclaimed row and a totals row, then clears all counters.
// A four-entry queue decouples the classifier from the counter back end, so
// cases keep entering while rows wait for the receiver; when the receiver
// stalls the output row holds and the queue fills, then o_in_ready drops.
// Reset clears the counters, the configuration and all handshake state;
// no clearing sweep follows it.
// Depends on dlcc_pkg, dlcc_front, dlcc_fifo and dlcc_back.
`default_nettype none

module decision_list_confusion_counter_top
    import dlcc_pkg::*;
#(
    parameter int MAX_CUES   = MAX_CUES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [FIRE_W-1:0]     i_cue_fires,
    input  wire logic                  i_true_class,
    input  wire logic                  i_last_case,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [1:0]                 o_row_kind,
    output logic [CIDX_W-1:0]          o_cue_index,
    output logic                       o_predicted_class,
    output logic [CNUM_W-1:0]          o_claimed_by,
    output logic [FIELD_W-1:0]         o_hit_count,
    output logic [FIELD_W-1:0]         o_false_alarm_count,
    output logic [FIELD_W-1:0]         o_miss_count,
    output logic [FIELD_W-1:0]         o_reject_count,
    output logic [FIELD_W-1:0]         o_claimed_count,
    output logic [FIELD_W-1:0]         o_open_before,
    output logic                       o_last
);

    logic [CNUM_W-1:0] r_cue_count;
    logic [FIRE_W-1:0] r_pred_mask;
    t_cfg              w_cfg;

    logic  w_push;
    t_case w_push_item;
    logic  w_full;
    logic  w_pop;
    logic  w_empty;
    t_case w_head;
    t_row  w_row;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cue_count <= '0;
            r_pred_mask <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_CUE_COUNT: r_cue_count <= i_cfg_data[CNUM_W-1:0];
                REG_PRED_MASK: r_pred_mask <= i_cfg_data[FIRE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Counts above the list capacity act as the capacity.
    assign w_cfg.cue_n     = (32'(r_cue_count) > MAX_CUES) ? CNUM_W'(MAX_CUES)
                                                          : r_cue_count;
    assign w_cfg.pred_mask = r_pred_mask;

    dlcc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_cue_fires  (i_cue_fires),
        .i_true_class (i_true_class),
        .i_last_case  (i_last_case),
        .i_full       (w_full),
        .o_push       (w_push),
        .o_item       (w_push_item)
    );

    dlcc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    dlcc_back #(
        .MAX_CUES   (MAX_CUES),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_empty (w_empty),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_row   (w_row)
    );

    assign o_row_kind          = w_row.row_kind;
    assign o_cue_index         = w_row.cue_index;
    assign o_predicted_class   = w_row.predicted_class;
    assign o_claimed_by        = w_row.claimed_by;
    assign o_hit_count         = w_row.hit_count;
    assign o_false_alarm_count = w_row.false_alarm_count;
    assign o_miss_count        = w_row.miss_count;
    assign o_reject_count      = w_row.reject_count;
    assign o_claimed_count     = w_row.claimed_count;
    assign o_open_before       = w_row.open_before;
    assign o_last              = w_row.last;

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// Testbench for decision_list_confusion_counter_top: drives cases and register
// writes, predicts every result row and checks it. Depends on dlcc_pkg and the block.

module testbench;
    import dlcc_pkg::*;

    localparam int unsigned COUNT_MAX = 65535;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 50;
    localparam int IDLE_PCT = 17;
    localparam int RANDOM_CASES = 250;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int SLOT_HIT = 0;
    localparam int SLOT_FALSE_ALARM = 1;
    localparam int SLOT_MISS = 2;
    localparam int SLOT_REJECT = 3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [FIRE_W-1:0]     i_cue_fires = '0;
    logic                  i_true_class = 1'b0;
    logic                  i_last_case = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [1:0]            o_row_kind;
    logic [CIDX_W-1:0]     o_cue_index;
    logic                  o_predicted_class;
    logic [CNUM_W-1:0]     o_claimed_by;
    logic [FIELD_W-1:0]    o_hit_count;
    logic [FIELD_W-1:0]    o_false_alarm_count;
    logic [FIELD_W-1:0]    o_miss_count;
    logic [FIELD_W-1:0]    o_reject_count;
    logic [FIELD_W-1:0]    o_claimed_count;
    logic [FIELD_W-1:0]    o_open_before;
    logic                  o_last;

    // Predicted state of the block.
    int unsigned       cue_tally [MAX_CUES_DEF][4];
    int unsigned       unclaimed_tally [4];
    int unsigned       batch_cases;
    logic [CNUM_W-1:0] cur_cue_count = '0;
    logic [FIRE_W-1:0] cur_pred_mask = '0;
    t_row              expected_rows [$];

    int mismatches = 0;
    int stall_cycles = 0;
    int out_hold = 0;
    int hold_requests = 0;
    int holds_started = 0;
    bit calm = 1'b0;

    decision_list_confusion_counter_top dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_cue_fires         (i_cue_fires),
        .i_true_class        (i_true_class),
        .i_last_case         (i_last_case),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_row_kind          (o_row_kind),
        .o_cue_index         (o_cue_index),
        .o_predicted_class   (o_predicted_class),
        .o_claimed_by        (o_claimed_by),
        .o_hit_count         (o_hit_count),
        .o_false_alarm_count (o_false_alarm_count),
        .o_miss_count        (o_miss_count),
        .o_reject_count      (o_reject_count),
        .o_claimed_count     (o_claimed_count),
        .o_open_before       (o_open_before),
        .o_last              (o_last)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic int unsigned sat_sum(int unsigned a, int unsigned b);
        return (a + b > COUNT_MAX) ? COUNT_MAX : a + b;
    endfunction

    function automatic void clear_tallies();
        for (int i = 0; i < MAX_CUES_DEF; i++) begin
            for (int j = 0; j < 4; j++) cue_tally[i][j] = 0;
        end
        for (int j = 0; j < 4; j++) unclaimed_tally[j] = 0;
        batch_cases = 0;
    endfunction

    function automatic t_row stats_row(t_row_kind kind, int unsigned idx, logic pc,
                                       int unsigned cb, int unsigned h, int unsigned fa,
                                       int unsigned m, int unsigned r, int unsigned still_open,
                                       logic fin);
        t_row row;
        int unsigned sum;
        sum = sat_sum(sat_sum(h, fa), sat_sum(m, r));
        row.row_kind          = kind;
        row.cue_index         = idx[CIDX_W-1:0];
        row.predicted_class   = pc;
        row.claimed_by        = cb[CNUM_W-1:0];
        row.hit_count         = h[FIELD_W-1:0];
        row.false_alarm_count = fa[FIELD_W-1:0];
        row.miss_count        = m[FIELD_W-1:0];
        row.reject_count      = r[FIELD_W-1:0];
        row.claimed_count     = sum[FIELD_W-1:0];
        row.open_before       = still_open[FIELD_W-1:0];
        row.last              = fin;
        return row;
    endfunction

    // Counts one case and queues the rows it should produce.
    function automatic void score_case(logic [FIRE_W-1:0] fires, logic truth, logic fin);
        int unsigned n;
        int unsigned claimer;
        int unsigned slot;
        int unsigned still_open;
        int unsigned claimed;
        int unsigned totals [4];
        logic pred;
        n = (cur_cue_count > MAX_CUES_DEF) ? MAX_CUES_DEF : cur_cue_count;
        claimer = 0;
        for (int unsigned i = 0; i < n; i++) begin
            if (fires[i] && claimer == 0) claimer = i + 1;
        end
        if (claimer != 0) pred = cur_pred_mask[claimer - 1];
        else if (n == 0) pred = 1'b1;
        else pred = ~cur_pred_mask[n - 1];
        slot = pred ? (truth ? SLOT_HIT : SLOT_FALSE_ALARM) : (truth ? SLOT_MISS : SLOT_REJECT);
        if (claimer != 0) cue_tally[claimer - 1][slot] = sat_sum(cue_tally[claimer - 1][slot], 1);
        else unclaimed_tally[slot] = sat_sum(unclaimed_tally[slot], 1);
        batch_cases = sat_sum(batch_cases, 1);

        if (!fin) begin
            expected_rows.push_back(stats_row(ROW_CASE, 0, pred, claimer, 0, 0, 0, 0, 0, 1'b1));
            return;
        end

        // Batch end: cue rows in list order, then the unclaimed and totals rows.
        still_open = batch_cases;
        for (int j = 0; j < 4; j++) totals[j] = unclaimed_tally[j];
        for (int unsigned i = 0; i < n; i++) begin
            expected_rows.push_back(stats_row(ROW_CUE, i, 1'b0, 0, cue_tally[i][0],
                cue_tally[i][1], cue_tally[i][2], cue_tally[i][3], still_open, 1'b0));
            claimed = sat_sum(sat_sum(cue_tally[i][0], cue_tally[i][1]),
                              sat_sum(cue_tally[i][2], cue_tally[i][3]));
            still_open = (still_open > claimed) ? still_open - claimed : 0;
            for (int j = 0; j < 4; j++) totals[j] = sat_sum(totals[j], cue_tally[i][j]);
        end
        expected_rows.push_back(stats_row(ROW_UNCL, 0, 1'b0, 0, unclaimed_tally[0],
            unclaimed_tally[1], unclaimed_tally[2], unclaimed_tally[3], still_open, 1'b0));
        expected_rows.push_back(stats_row(ROW_TOTAL, 0, pred, claimer, totals[0], totals[1],
            totals[2], totals[3], still_open, 1'b1));
        clear_tallies();
    endfunction

    function automatic string row_text(t_row r);
        return $sformatf({"kind=%0d cue=%0d pred=%0d by=%0d hit=%0d fa=%0d miss=%0d",
                          " rej=%0d sum=%0d open=%0d last=%0d"},
            r.row_kind, r.cue_index, r.predicted_class, r.claimed_by, r.hit_count,
            r.false_alarm_count, r.miss_count, r.reject_count, r.claimed_count,
            r.open_before, r.last);
    endfunction

    function automatic void note_failure(string what);
        if (mismatches < 10) $display("%s", what);
        mismatches++;
    endfunction

    function automatic logic [FIRE_W-1:0] random_fires();
        case ($urandom_range(3))
            0: return '0;
            1: return 16'h0001 << $urandom_range(15);
            2: return FIRE_W'($urandom_range(65535));
            default: return FIRE_W'($urandom_range(65535)) & (16'hFFFF << $urandom_range(15));
        endcase
    endfunction

    // Result checker: every row transfer is matched against the oldest prediction.
    always @(posedge i_clk) begin
        t_row got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.row_kind          = t_row_kind'(o_row_kind);
            got.cue_index         = o_cue_index;
            got.predicted_class   = o_predicted_class;
            got.claimed_by        = o_claimed_by;
            got.hit_count         = o_hit_count;
            got.false_alarm_count = o_false_alarm_count;
            got.miss_count        = o_miss_count;
            got.reject_count      = o_reject_count;
            got.claimed_count     = o_claimed_count;
            got.open_before       = o_open_before;
            got.last              = o_last;
            if (expected_rows.size() == 0) begin
                note_failure({"unexpected row: ", row_text(got)});
            end else begin
                if (got !== expected_rows[0])
                    note_failure({"row mismatch\n  expected ", row_text(expected_rows[0]),
                                  "\n  actual   ", row_text(got)});
                void'(expected_rows.pop_front());
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (out_hold != 0) begin
            i_out_ready <= 1'b0;
            out_hold <= out_hold - 1;
        end else if (holds_started != hold_requests) begin
            i_out_ready <= 1'b0;
            out_hold <= HOLD_CYCLES;
            holds_started <= holds_started + 1;
        end else begin
            i_out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Valid is left high on return so back-to-back transfers never lower and raise it
    // in the same step; an idle cycle or a drain lowers it.
    task automatic send_case(logic [FIRE_W-1:0] fires, logic truth, logic fin);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_cue_fires  <= fires;
        i_true_class <= truth;
        i_last_case  <= fin;
        do @(posedge i_clk); while (!o_in_ready);
        score_case(fires, truth, fin);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_rows.size() != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_CUE_COUNT) cur_cue_count = value[CNUM_W-1:0];
        else if (idx == REG_PRED_MASK) cur_pred_mask = value;
    endtask

    task automatic set_config(int unsigned count, logic [CFG_DATA_W-1:0] mask);
        wait_drained();
        write_reg(REG_CUE_COUNT, count[CFG_DATA_W-1:0]);
        write_reg(REG_PRED_MASK, mask);
        i_cfg_valid <= 1'b0;
    endtask

    // Right after reset there are no cues, so every case is unclaimed with class 1.
    task automatic test_empty_list();
        send_case(16'h0000, 1'b1, 1'b0);
        send_case(16'hFFFF, 1'b0, 1'b0);
        send_case(16'h0001, 1'b1, 1'b1);
    endtask

    task automatic test_claim_priority();
        set_config(4, 16'h000A);
        send_case(16'h0000, 1'b0, 1'b0);
        send_case(16'hFFFF, 1'b1, 1'b0);
        send_case(16'hFFF0, 1'b1, 1'b0);
        send_case(16'h000C, 1'b0, 1'b0);
        send_case(16'h0008, 1'b1, 1'b0);
        send_case(16'h0006, 1'b0, 1'b0);
        send_case(16'h0002, 1'b1, 1'b1);
    endtask

    // Full list, and counts above the cue limit that behave as the full list.
    task automatic test_cue_count_limits();
        set_config(16, 16'hFFFF);
        send_case(16'h8000, 1'b1, 1'b0);
        send_case(16'h0000, 1'b0, 1'b0);
        send_case(16'h8000, 1'b0, 1'b1);
        set_config(31, 16'h0000);
        send_case(16'h8000, 1'b1, 1'b0);
        send_case(16'h4000, 1'b0, 1'b1);
        set_config(17, 16'h5555);
        send_case(16'h0000, 1'b1, 1'b1);
    endtask

    // Registers change inside a batch; the write to an unused index must do nothing.
    task automatic test_mid_batch_config();
        set_config(2, 16'h0001);
        send_case(16'h0001, 1'b1, 1'b0);
        send_case(16'h0002, 1'b0, 1'b0);
        wait_drained();
        write_reg(REG_PRED_MASK, 16'h0002);
        write_reg(REG_CUE_COUNT, 16'd3);
        write_reg(REG_UNUSED, 16'hFFFF);
        i_cfg_valid <= 1'b0;
        send_case(16'h0001, 1'b0, 1'b0);
        send_case(16'h0004, 1'b1, 1'b0);
        send_case(16'h0000, 1'b1, 1'b1);
    endtask

    // The receiver holds off while cases keep coming, so the queue fills and input
    // stalls; then the sender waits until every row has come back.
    task automatic test_backpressure();
        set_config(16, CFG_DATA_W'($urandom_range(65535)));
        hold_requests++;
        for (int k = 0; k < 24; k++)
            send_case(random_fires(), 1'($urandom_range(1)), k == 11 || k == 23);
        wait_drained();
    endtask

    task automatic test_random_batches();
        int sent = 0;
        int batch_len;
        int unsigned count;
        while (sent < RANDOM_CASES) begin
            if ($urandom_range(2) == 0) begin
                count = ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(1, 16);
                set_config(count, CFG_DATA_W'($urandom_range(65535)));
            end
            calm = (sent >= 100 && sent < 180);
            batch_len = $urandom_range(1, 12);
            for (int k = 1; k <= batch_len; k++)
                send_case(random_fires(), 1'($urandom_range(1)), k == batch_len);
            sent += batch_len;
        end
        calm = 1'b0;
    endtask

    initial begin
        clear_tallies();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_list();
        test_claim_priority();
        test_cue_count_limits();
        test_mid_batch_config();
        test_backpressure();
        test_random_batches();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_rows.size() != 0)
            note_failure($sformatf("%0d expected rows never arrived", expected_rows.size()));
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
